FILE: hw/rtl/ccl_pkg.sv
// shared constants, codes and control structs of the connected component labeler
`default_nettype none
package ccl_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VW  = $clog2(MAX_VERTICES);   // vertex id width
  localparam int CW  = VW + 1;                 // vertex count width
  localparam int EW  = $clog2(MAX_EDGES);      // edge index width
  localparam int FW  = EW + 1;                 // edge fill width

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTREADY = 2'd3
  } status_t;

  localparam logic REG_VCOUNT = 1'b0;

  typedef struct packed {
    logic acc_clear;
    logic acc_add;
    logic acc_read;
    logic acc_run;
    logic q_done;
    logic run_done;
    logic vidx_clr;
    logic vidx_inc;
    logic eidx_clr;
    logic eidx_inc;
    logic init_wr;
    logic sel_edge;
    logic offer_dir;
    logic offer_wr;
    logic commit_sel;
    logic commit_wr;
    logic any_clr;
    logic round_inc;
  } cmd_t;

  typedef struct packed {
    logic vidx_last;
    logic eidx_last;
    logic edges_empty;
    logic any;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ccl_ctrl.sv
// sequencer of the labeler: accepts items and steps the propagation passes
`default_nettype none
module ccl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_opcode,
  output logic               in_stall,
  input  wire ccl_pkg::sts_t sts,
  output ccl_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_INIT, S_RSTART, S_EFETCH, S_OFFA, S_WRA,
    S_OFFB, S_WRB, S_CRD, S_CWR, S_CHK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  ccl_pkg::opcode_t op;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;
  assign op       = ccl_pkg::opcode_t'(in_opcode);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            ccl_pkg::OP_CLEAR: cmd.acc_clear = 1'b1;
            ccl_pkg::OP_ADD:   cmd.acc_add = 1'b1;
            ccl_pkg::OP_READ: begin
              cmd.acc_read = 1'b1;
              state_nxt    = S_QRD;
            end
            ccl_pkg::OP_RUN: begin
              cmd.acc_run  = 1'b1;
              cmd.vidx_clr = 1'b1;
              state_nxt    = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        cmd.q_done = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.vidx_last) state_nxt = S_RSTART;
        else cmd.vidx_inc = 1'b1;
      end
      S_RSTART: begin
        cmd.round_inc = 1'b1;
        cmd.any_clr   = 1'b1;
        cmd.eidx_clr  = 1'b1;
        cmd.vidx_clr  = 1'b1;
        state_nxt     = sts.edges_empty ? S_CRD : S_EFETCH;
      end
      S_EFETCH: state_nxt = S_OFFA;
      S_OFFA: begin
        cmd.sel_edge = 1'b1;
        state_nxt    = S_WRA;
      end
      S_WRA: begin
        cmd.sel_edge = 1'b1;
        cmd.offer_wr = 1'b1;
        state_nxt    = S_OFFB;
      end
      S_OFFB: begin
        cmd.sel_edge  = 1'b1;
        cmd.offer_dir = 1'b1;
        state_nxt     = S_WRB;
      end
      S_WRB: begin
        cmd.sel_edge  = 1'b1;
        cmd.offer_dir = 1'b1;
        cmd.offer_wr  = 1'b1;
        if (sts.eidx_last) state_nxt = S_CRD;
        else begin
          cmd.eidx_inc = 1'b1;
          state_nxt    = S_EFETCH;
        end
      end
      S_CRD: begin
        cmd.commit_sel = 1'b1;
        state_nxt      = S_CWR;
      end
      S_CWR: begin
        cmd.commit_sel = 1'b1;
        cmd.commit_wr  = 1'b1;
        if (sts.vidx_last) state_nxt = S_CHK;
        else begin
          cmd.vidx_inc = 1'b1;
          state_nxt    = S_CRD;
        end
      end
      S_CHK: state_nxt = sts.any ? S_RSTART : S_DONE;
      S_DONE: begin
        cmd.run_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ccl_dp.sv
// datapath of the labeler: edge store, label memories, counters and result register
`default_nettype none
module ccl_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  input  wire logic [ccl_pkg::VW-1:0] in_vertex_a,
  input  wire logic [ccl_pkg::VW-1:0] in_vertex_b,
  input  wire logic                   out_stall,
  input  wire ccl_pkg::cmd_t          cmd,
  output ccl_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [ccl_pkg::VW-1:0]      out_label,
  output logic [ccl_pkg::CW-1:0]      out_rounds,
  output logic [ccl_pkg::FW-1:0]      out_edge_total,
  output logic [1:0]                  out_status
);

  localparam int VW = ccl_pkg::VW;
  localparam int CW = ccl_pkg::CW;
  localparam int EW = ccl_pkg::EW;
  localparam int FW = ccl_pkg::FW;

  logic [VW-1:0] efirst_mem  [ccl_pkg::MAX_EDGES];
  logic [VW-1:0] esecond_mem [ccl_pkg::MAX_EDGES];
  logic [VW-1:0] lnow_mem    [ccl_pkg::MAX_VERTICES];
  logic [VW-1:0] lnext_mem   [ccl_pkg::MAX_VERTICES];
  logic          anow_mem    [ccl_pkg::MAX_VERTICES];
  logic          anext_mem   [ccl_pkg::MAX_VERTICES];

  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] vidx_r;
  logic [FW-1:0] eidx_r;
  logic [CW-1:0] round_r;
  logic          ready_r, any_r;
  ccl_pkg::status_t qst_r;

  logic [VW-1:0] ea_q, eb_q, lnow_q, lnext_q;
  logic          anow_q, anext_q;

  logic             out_valid_r;
  logic [VW-1:0]    out_label_r;
  logic [CW-1:0]    out_rounds_r;
  logic [FW-1:0]    out_edge_total_r;
  ccl_pkg::status_t out_status_r;

  logic             cfg_wr;
  logic [CW-1:0]    wval;
  logic             a_ok, b_ok, full, store;
  ccl_pkg::status_t add_st, rd_st;
  logic [VW-1:0]    lnow_raddr, lnext_raddr, offer_waddr, vaddr;
  logic             edge_ok, offer_fire;

  assign vaddr = vidx_r[VW-1:0];

  // register port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ccl_pkg::REG_VCOUNT);
  assign wval   = pwdata[CW-1:0];
  always_comb begin
    vcnt_nxt = vcnt_r;
    if (cfg_wr) begin
      if (wval == '0) vcnt_nxt = CW'(1);
      else if (wval > CW'(ccl_pkg::MAX_VERTICES)) vcnt_nxt = CW'(ccl_pkg::MAX_VERTICES);
      else vcnt_nxt = wval;
    end
  end
  assign prdata = (paddr[2] == ccl_pkg::REG_VCOUNT) ? {{(32-CW){1'b0}}, vcnt_r} : '0;

  // item checks
  assign a_ok  = {1'b0, in_vertex_a} < vcnt_r;
  assign b_ok  = {1'b0, in_vertex_b} < vcnt_r;
  assign full  = fill_r == FW'(ccl_pkg::MAX_EDGES);
  assign store = cmd.acc_add && a_ok && b_ok && !full;
  assign add_st = !(a_ok && b_ok) ? ccl_pkg::ST_RANGE :
                  full            ? ccl_pkg::ST_FULL  : ccl_pkg::ST_OK;
  assign rd_st  = !a_ok    ? ccl_pkg::ST_RANGE    :
                  !ready_r ? ccl_pkg::ST_NOTREADY : ccl_pkg::ST_OK;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.acc_clear) fill_nxt = '0;
    else if (store)    fill_nxt = fill_r + FW'(1);
  end

  // memory addressing
  assign lnow_raddr  = cmd.sel_edge ? (cmd.offer_dir ? eb_q : ea_q) : in_vertex_a;
  assign lnext_raddr = cmd.commit_sel ? vaddr : (cmd.offer_dir ? ea_q : eb_q);
  assign offer_waddr = cmd.offer_dir ? ea_q : eb_q;
  assign edge_ok     = ({1'b0, ea_q} < vcnt_r) && ({1'b0, eb_q} < vcnt_r);
  assign offer_fire  = cmd.offer_wr && edge_ok && anow_q && (lnow_q < lnext_q);

  always_ff @(posedge clk) begin
    if (store) begin
      efirst_mem[fill_r[EW-1:0]]  <= in_vertex_a;
      esecond_mem[fill_r[EW-1:0]] <= in_vertex_b;
    end
    ea_q <= efirst_mem[eidx_r[EW-1:0]];
    eb_q <= esecond_mem[eidx_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) lnow_mem[vaddr] <= vaddr;
    else if (cmd.commit_wr) lnow_mem[vaddr] <= lnext_q;
    lnow_q <= lnow_mem[lnow_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) lnext_mem[vaddr] <= vaddr;
    else if (offer_fire) lnext_mem[offer_waddr] <= lnow_q;
    lnext_q <= lnext_mem[lnext_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) anow_mem[vaddr] <= 1'b1;
    else if (cmd.commit_wr) anow_mem[vaddr] <= anext_q;
    anow_q <= anow_mem[lnow_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr || cmd.commit_wr) anext_mem[vaddr] <= 1'b0;
    else if (offer_fire) anext_mem[offer_waddr] <= 1'b1;
    anext_q <= anext_mem[vaddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= CW'(ccl_pkg::MAX_VERTICES);
      fill_r      <= '0;
      ready_r     <= 1'b0;
      round_r     <= '0;
      any_r       <= 1'b0;
      vidx_r      <= '0;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r <= vcnt_nxt;
      fill_r <= fill_nxt;
      if (cfg_wr || cmd.acc_clear || store) ready_r <= 1'b0;
      else if (cmd.run_done) ready_r <= 1'b1;
      if (cmd.acc_run) round_r <= '0;
      else if (cmd.round_inc) round_r <= round_r + CW'(1);
      if (cmd.any_clr) any_r <= 1'b0;
      else if (cmd.commit_wr) any_r <= any_r | anext_q;
      if (cmd.vidx_clr) vidx_r <= '0;
      else if (cmd.vidx_inc) vidx_r <= vidx_r + CW'(1);
      if (cmd.eidx_clr) eidx_r <= '0;
      else if (cmd.eidx_inc) eidx_r <= eidx_r + FW'(1);
      if (cmd.acc_clear || cmd.acc_add || cmd.q_done || cmd.run_done) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.acc_read) qst_r <= rd_st;
    if (cmd.acc_clear || cmd.acc_add || cmd.q_done || cmd.run_done) begin
      out_rounds_r     <= cmd.acc_run ? '0 : round_r;
      out_edge_total_r <= fill_nxt;
      out_label_r      <= (cmd.q_done && qst_r == ccl_pkg::ST_OK) ? lnow_q : '0;
      if (cmd.acc_add) out_status_r <= add_st;
      else if (cmd.q_done) out_status_r <= qst_r;
      else out_status_r <= ccl_pkg::ST_OK;
    end
  end

  assign sts.vidx_last   = vidx_r == (vcnt_r - CW'(1));
  assign sts.eidx_last   = eidx_r == (fill_r - FW'(1));
  assign sts.edges_empty = fill_r == '0;
  assign sts.any         = any_r;
  assign sts.out_busy    = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_label      = out_label_r;
  assign out_rounds     = out_rounds_r;
  assign out_edge_total = out_edge_total_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

FILE: hw/rtl/connected_component_labeler.sv
// top level of the connected component labeler
//
// Connected component labeler by label propagation. Items carry an opcode:
// clear edges, add edge (vertex_a, vertex_b, stored as undirected), run
// labeling, read label of vertex_a. Each item gives exactly one result
// item with label, rounds of the last run, edges stored and status.
// Clear and add answer in the next cycle and stream back to back while the
// output is not stalled; a read adds one label memory read. A run works
// over single port memories: labels are seeded per vertex, then each round
// gives each stored edge a fetch and a read and a conditional write per
// direction, and each vertex a read and a write to commit the new labels
// and activity, over the vertices that vertex_count sets. Only one item is
// in work at a time; a finished result sits in an output register and the
// input is stalled while that result is held off, so the next item enters
// in the cycle the result is taken at the earliest. vertex_count is at byte
// address 0 of the register port; writes keep bits 10:0, 0 reads back as 1
// and values above 1024 as 1024, and any write invalidates computed labels.
`default_nettype none
module connected_component_labeler (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // register port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // item input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [ccl_pkg::VW-1:0] in_vertex_a,
  input  wire logic [ccl_pkg::VW-1:0] in_vertex_b,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ccl_pkg::VW-1:0]      out_label,
  output logic [ccl_pkg::CW-1:0]      out_rounds,
  output logic [ccl_pkg::FW-1:0]      out_edge_total,
  output logic [1:0]                  out_status
);

  ccl_pkg::cmd_t cmd;   // sequencer commands
  ccl_pkg::sts_t sts;   // datapath status back to the sequencer

  assign pready = 1'b1;

  ccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_label      (out_label),
    .out_rounds     (out_rounds),
    .out_edge_total (out_edge_total),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/ccl_checker.sv
// port checker of the labeler and its bind to the top level
`default_nettype none
module ccl_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic [1:0]             in_opcode,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [ccl_pkg::VW-1:0] out_label,
  input wire logic [ccl_pkg::FW-1:0] out_edge_total,
  input wire logic [1:0]             out_status
);

  // a stalled result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a nonzero label only comes with ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label != '0 |-> out_status == ccl_pkg::ST_OK)
    else $error("label given with failing status");

  // edge count never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_total <= ccl_pkg::FW'(ccl_pkg::MAX_EDGES))
    else $error("edge count beyond store depth");

  // a clear item answers on the next cycle with an empty store
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == ccl_pkg::OP_CLEAR
      |=> out_valid && out_edge_total == '0 && out_status == ccl_pkg::ST_OK)
    else $error("clear item result wrong");

endmodule

bind connected_component_labeler ccl_checker u_ccl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_label      (out_label),
  .out_edge_total (out_edge_total),
  .out_status     (out_status)
);
`default_nettype wire
